// ===== rtl/size_class_block_allocator_defines.svh =====
// Assertion macros for the size-class block allocator.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCBA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/scba_pkg.sv =====
// Shared constants, codes and types for the size-class block allocator.
// No dependencies; used by the allocator top and the head table.
`timescale 1ns / 1ps
`default_nettype none

package scba_pkg;

  localparam int BLOCK_BYTES    = 8;
  localparam int BLOCK_SHIFT    = 3;
  localparam int NUM_CLASSES    = 16;
  localparam int CLASS_W        = 4;
  localparam int CHUNK_BLOCKS   = 256;
  localparam int CHUNK_SHIFT    = 8;
  localparam int ARENA_BLOCKS   = 4096;
  localparam int ADDR_W         = 12;
  localparam int NUM_CHUNKS     = ARENA_BLOCKS / CHUNK_BLOCKS;
  localparam int CHUNK_IDX_W    = ADDR_W - CHUNK_SHIFT;
  localparam int CHUNK_CNT_W    = CHUNK_IDX_W + 1;
  localparam int REM_W          = CHUNK_SHIFT + 1;
  localparam int BLOCKS_W       = CLASS_W + 1;
  localparam int SIZE_W         = 12;
  localparam int MAX_POOL_BYTES = NUM_CLASSES * BLOCK_BYTES;

  // Request commands.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_FREED     = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_NO_MEMORY = 2'd3;

  // A list link: valid flag and the block index it points at.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
  } link_t;

  localparam int LINK_W = ADDR_W + 1;

  // Write into the table of class heads.
  typedef struct packed {
    logic               en;
    logic [CLASS_W-1:0] idx;
    link_t              entry;
  } head_wr_t;

endpackage

`default_nettype wire

// ===== rtl/size_class_block_allocator.sv =====
// Size-class block allocator: one request word in, one result word out.
// Each request passes an execute state and a result state; pops and chunk refills add a
// state between the two, for the link RAM read or the refill step.
// A new request is taken only once the result word of the last has been written out.
// Reset clears the class-list valid flags, the bump state and the chunk count; the
// link RAM is not cleared, as a link is only read after it has been written.
`timescale 1ns / 1ps
`default_nettype none
`include "size_class_block_allocator_defines.svh"

module size_class_block_allocator (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire logic                         cmd,
  input  wire logic [scba_pkg::SIZE_W-1:0]  size_bytes,
  input  wire logic [scba_pkg::ADDR_W-1:0]  block_address,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output logic      [scba_pkg::ADDR_W-1:0]  granted_address,
  output logic      [1:0]                   status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_REFILL,
    S_RESP
  } state_t;

  state_t state;

  logic                             cmd_q;
  logic                             too_large_q;
  logic [scba_pkg::BLOCKS_W-1:0]    blocks_q;
  logic [scba_pkg::CLASS_W-1:0]     cls_q;
  logic [scba_pkg::ADDR_W-1:0]      addr_q;
  logic [scba_pkg::ADDR_W-1:0]      bump_pointer;
  logic [scba_pkg::REM_W-1:0]       bump_remaining;
  logic [scba_pkg::CHUNK_CNT_W-1:0] next_chunk;
  logic [scba_pkg::ADDR_W-1:0]      res_addr;
  logic [1:0]                       res_status;

  logic [scba_pkg::SIZE_W:0]        size_round;
  logic [scba_pkg::BLOCKS_W-1:0]    blocks_raw;
  logic [scba_pkg::BLOCKS_W-1:0]    blocks_in;
  logic [scba_pkg::BLOCKS_W-1:0]    blocks_m1;
  logic                             too_large_in;
  logic [scba_pkg::REM_W-1:0]       rem_m1;
  logic [scba_pkg::CLASS_W-1:0]     rem_cls;
  logic [scba_pkg::CLASS_W-1:0]     head_idx;
  logic                             need_chunk;
  logic [scba_pkg::ADDR_W-1:0]      chunk_base;
  logic [scba_pkg::REM_W:0]         chunk_fill;

  scba_pkg::link_t                  head_rd;
  scba_pkg::head_wr_t               head_wr;
  logic                             ram_we;
  logic [scba_pkg::ADDR_W-1:0]      ram_waddr;
  logic [scba_pkg::LINK_W-1:0]      ram_wdata;
  logic                             ram_re;
  logic [scba_pkg::LINK_W-1:0]      ram_rdata;

  // Size to block count; only meaningful when the size fits the pools.
  assign size_round   = {1'b0, size_bytes} + (scba_pkg::SIZE_W + 1)'(scba_pkg::BLOCK_BYTES - 1);
  assign blocks_raw   = size_round[scba_pkg::BLOCK_SHIFT +: scba_pkg::BLOCKS_W];
  assign blocks_in    = (blocks_raw == '0) ? scba_pkg::BLOCKS_W'(1) : blocks_raw;
  assign blocks_m1    = blocks_in - scba_pkg::BLOCKS_W'(1);
  assign too_large_in = size_bytes > scba_pkg::SIZE_W'(scba_pkg::MAX_POOL_BYTES);

  // The chunk remainder is always smaller than the request, so it names a class.
  assign rem_m1     = bump_remaining - scba_pkg::REM_W'(1);
  assign rem_cls    = rem_m1[scba_pkg::CLASS_W-1:0];
  assign head_idx   = (state == S_REFILL) ? rem_cls : cls_q;
  assign need_chunk = scba_pkg::REM_W'(blocks_q) > bump_remaining;
  assign chunk_base = {next_chunk[scba_pkg::CHUNK_IDX_W-1:0], {scba_pkg::CHUNK_SHIFT{1'b0}}};
  assign chunk_fill = {2'b00, bump_pointer[scba_pkg::CHUNK_SHIFT-1:0]}
                      + {1'b0, bump_remaining};

  assign req_stall = (state != S_IDLE);

  scba_head_table u_heads (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (head_idx),
    .rd_entry (head_rd),
    .wr       (head_wr)
  );

  scba_link_ram #(
    .DEPTH (scba_pkg::ARENA_BLOCKS),
    .WIDTH (scba_pkg::LINK_W)
  ) u_links (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_rd.addr),
    .rdata (ram_rdata)
  );

  // Pushes write the old head into the block's link; a pop reads the link back.
  always_comb begin
    head_wr   = '0;
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = head_rd;
    ram_re    = 1'b0;
    case (state)
      S_EXEC: begin
        if (!too_large_q) begin
          if (cmd_q == scba_pkg::CMD_FREE) begin
            ram_we             = 1'b1;
            head_wr.en         = 1'b1;
            head_wr.idx        = cls_q;
            head_wr.entry.valid = 1'b1;
            head_wr.entry.addr  = addr_q;
          end else if (head_rd.valid) begin
            ram_re = 1'b1;
          end
        end
      end
      S_POP: begin
        head_wr.en    = 1'b1;
        head_wr.idx   = cls_q;
        head_wr.entry = scba_pkg::link_t'(ram_rdata);
      end
      S_REFILL: begin
        if (bump_remaining != '0) begin
          ram_we              = 1'b1;
          ram_waddr           = bump_pointer;
          head_wr.en          = 1'b1;
          head_wr.idx         = rem_cls;
          head_wr.entry.valid = 1'b1;
          head_wr.entry.addr  = bump_pointer;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      rsp_valid      <= 1'b0;
      bump_pointer   <= '0;
      bump_remaining <= '0;
      next_chunk     <= '0;
    end else begin
      // In the result state the word register is refilled below instead.
      if (rsp_valid && !rsp_stall && state != S_RESP) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd_q       <= cmd;
            too_large_q <= too_large_in;
            blocks_q    <= blocks_in;
            cls_q       <= blocks_m1[scba_pkg::CLASS_W-1:0];
            addr_q      <= block_address;
            state       <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_addr <= '0;
          if (too_large_q) begin
            res_status <= scba_pkg::ST_TOO_LARGE;
            state      <= S_RESP;
          end else if (cmd_q == scba_pkg::CMD_FREE) begin
            res_status <= scba_pkg::ST_FREED;
            state      <= S_RESP;
          end else if (head_rd.valid) begin
            res_addr   <= head_rd.addr;
            res_status <= scba_pkg::ST_ALLOCATED;
            state      <= S_POP;
          end else if (need_chunk) begin
            state <= S_REFILL;
          end else begin
            res_addr       <= bump_pointer;
            res_status     <= scba_pkg::ST_ALLOCATED;
            bump_pointer   <= bump_pointer + scba_pkg::ADDR_W'(blocks_q);
            bump_remaining <= bump_remaining - scba_pkg::REM_W'(blocks_q);
            state          <= S_RESP;
          end
        end
        S_POP: begin
          state <= S_RESP;
        end
        S_REFILL: begin
          if (next_chunk < scba_pkg::CHUNK_CNT_W'(scba_pkg::NUM_CHUNKS)) begin
            res_addr       <= chunk_base;
            res_status     <= scba_pkg::ST_ALLOCATED;
            bump_pointer   <= chunk_base + scba_pkg::ADDR_W'(blocks_q);
            bump_remaining <= scba_pkg::REM_W'(scba_pkg::CHUNK_BLOCKS)
                              - scba_pkg::REM_W'(blocks_q);
            next_chunk     <= next_chunk + scba_pkg::CHUNK_CNT_W'(1);
          end else begin
            res_addr       <= '0;
            res_status     <= scba_pkg::ST_NO_MEMORY;
            bump_remaining <= '0;
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid       <= 1'b1;
            granted_address <= res_addr;
            status          <= res_status;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SCBA_ASSERT_SAME(a_grant_zero, rsp_valid && status != scba_pkg::ST_ALLOCATED,
                    granted_address == '0, "granted address not zero on a non-grant word")
  `SCBA_ASSERT_SAME(a_bump_in_chunk, bump_remaining != '0,
                    chunk_fill == (scba_pkg::REM_W + 1)'(scba_pkg::CHUNK_BLOCKS),
                    "bump pointer and remainder disagree about the chunk end")
  `SCBA_ASSERT_NEXT(a_pop_writes_head, state == S_POP,
                    state == S_RESP && $past(head_wr.en) && $past(head_wr.idx) == cls_q,
                    "pop did not update its class head")

endmodule

`default_nettype wire

// ===== rtl/scba_link_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; holds the per-block list links of the allocator.
`timescale 1ns / 1ps
`default_nettype none

module scba_link_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 13
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scba_head_table.sv =====
// Heads of the per-class free lists, with a valid flag per class cleared by reset.
// Depends on scba_pkg for widths and the link and write types.
`timescale 1ns / 1ps
`default_nettype none

module scba_head_table (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [scba_pkg::CLASS_W-1:0] rd_idx,
  output scba_pkg::link_t                  rd_entry,
  input  wire scba_pkg::head_wr_t          wr
);

  logic                        head_valid [scba_pkg::NUM_CLASSES];
  logic [scba_pkg::ADDR_W-1:0] head_addr  [scba_pkg::NUM_CLASSES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < scba_pkg::NUM_CLASSES; i++) begin
        head_valid[i] <= 1'b0;
      end
    end else if (wr.en) begin
      head_valid[wr.idx] <= wr.entry.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      head_addr[wr.idx] <= wr.entry.addr;
    end
  end

  assign rd_entry.valid = head_valid[rd_idx];
  assign rd_entry.addr  = head_addr[rd_idx];

endmodule

`default_nettype wire

// ===== verif/size_class_block_allocator_checker.sv =====
// Result checker for the size-class block allocator: watches both channels, predicts each result.
// Depends on scba_pkg for widths, command and status codes and the link type.
`timescale 1ns / 1ps

module size_class_block_allocator_checker
  import scba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  logic              cmd,
  input  logic [SIZE_W-1:0] size_bytes,
  input  logic [ADDR_W-1:0] block_address,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  logic [ADDR_W-1:0] granted_address,
  input  logic [1:0]        status,
  output int                fail_count,
  output int                owed
);

  typedef struct packed {
    logic [ADDR_W-1:0] granted;
    logic [1:0]        status;
  } outcome_t;

  // Shadow of the allocator state.
  link_t                  class_head [NUM_CLASSES];
  link_t                  block_link [ARENA_BLOCKS];
  logic [ADDR_W-1:0]      bump_ptr;
  logic [REM_W-1:0]       bump_left;
  logic [CHUNK_CNT_W-1:0] chunks_taken;

  outcome_t outcomes_due [$];
  int       results_seen;

  function automatic void push_free_block(input logic [CLASS_W-1:0] cls,
                                          input logic [ADDR_W-1:0] addr);
    block_link[addr] = class_head[cls];
    class_head[cls]  = '{valid: 1'b1, addr: addr};
  endfunction

  function automatic outcome_t serve_request(input logic c, input logic [SIZE_W-1:0] sz,
                                             input logic [ADDR_W-1:0] ba);
    outcome_t          o;
    int                nblk;
    logic [CLASS_W-1:0] cls;
    logic [ADDR_W-1:0] a;
    o.granted = '0;
    o.status  = ST_TOO_LARGE;
    if (sz > MAX_POOL_BYTES) return o;
    // A zero size still takes one block.
    nblk = (int'(sz) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    if (nblk == 0) nblk = 1;
    cls = CLASS_W'(nblk - 1);
    if (c == CMD_FREE) begin
      push_free_block(cls, ba);
      o.status = ST_FREED;
    end else if (class_head[cls].valid) begin
      a               = class_head[cls].addr;
      class_head[cls] = block_link[a];
      o.granted       = a;
      o.status        = ST_ALLOCATED;
    end else begin
      o.status = ST_ALLOCATED;
      if (nblk > int'(bump_left)) begin
        // The leftover of the old chunk goes on the list for its own block count.
        if (bump_left != 0) push_free_block(CLASS_W'(bump_left - 1), bump_ptr);
        if (chunks_taken < NUM_CHUNKS) begin
          bump_ptr     = ADDR_W'(chunks_taken) << CHUNK_SHIFT;
          bump_left    = REM_W'(CHUNK_BLOCKS);
          chunks_taken = chunks_taken + 1'b1;
        end else begin
          bump_left = '0;
          o.status  = ST_NO_MEMORY;
        end
      end
      if (o.status == ST_ALLOCATED) begin
        o.granted = bump_ptr;
        bump_ptr  = bump_ptr + ADDR_W'(nblk);
        bump_left = bump_left - REM_W'(nblk);
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t due;
    outcome_t fresh;
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) class_head[i] = '0;
      bump_ptr     = '0;
      bump_left    = '0;
      chunks_taken = '0;
      outcomes_due.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      // The result is checked first, since it always belongs to an older word.
      if (rsp_valid && !rsp_stall) begin
        if (outcomes_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d with nothing owed: addr %h status %0d",
                     results_seen, granted_address, status);
        end else begin
          due = outcomes_due.pop_front();
          if (due.granted !== granted_address || due.status !== status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d: expected addr %h status %0d, got addr %h status %0d",
                       results_seen, due.granted, due.status, granted_address, status);
          end
        end
        results_seen++;
      end
      if (req_valid && !req_stall) begin
        fresh = serve_request(cmd, size_bytes, block_address);
        outcomes_due.push_back(fresh);
      end
    end
    owed = outcomes_due.size();
  end

endmodule

// ===== verif/size_class_block_allocator_tb.sv =====
// Testbench top for the size-class block allocator: clock, reset, request and stall stimulus.
// Depends on scba_pkg, the block itself and size_class_block_allocator_checker.
`timescale 1ns / 1ps

module size_class_block_allocator_tb;
  import scba_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 435;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } live_obj_t;

  typedef struct {
    logic              c;
    logic [SIZE_W-1:0] size;
  } sent_req_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic              cmd = CMD_ALLOC;
  logic [SIZE_W-1:0] size_bytes = '0;
  logic [ADDR_W-1:0] block_address = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  logic [ADDR_W-1:0] granted_address;
  logic [1:0]        status;

  int fail_count;
  int owed;
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  bit hold_request = 1'b0;
  bit hold_done    = 1'b0;

  live_obj_t live_objs [$];
  sent_req_t in_flight [$];

  size_class_block_allocator u_top (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .cmd             (cmd),
    .size_bytes      (size_bytes),
    .block_address   (block_address),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .granted_address (granted_address),
    .status          (status)
  );

  size_class_block_allocator_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .cmd             (cmd),
    .size_bytes      (size_bytes),
    .block_address   (block_address),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .granted_address (granted_address),
    .status          (status),
    .fail_count      (fail_count),
    .owed            (owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off that lets the block fill up.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Granted objects are remembered so that most frees return a real allocation.
  always @(posedge clk) begin : track_grants
    sent_req_t sent;
    if (!rst && rsp_valid && !rsp_stall && in_flight.size() != 0) begin
      sent = in_flight.pop_front();
      if (sent.c == CMD_ALLOC && status == ST_ALLOCATED)
        live_objs.push_back('{addr: granted_address, size: sent.size});
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL size_class_block_allocator");
        $finish;
      end
    end
  end

  task automatic issue(input logic c, input logic [SIZE_W-1:0] s, input logic [ADDR_W-1:0] a);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid     <= 1'b1;
    cmd           <= c;
    size_bytes    <= s;
    block_address <= a;
    do @(posedge clk); while (req_stall);
    in_flight.push_back('{c: c, size: s});
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (owed != 0) @(posedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return SIZE_W'($urandom_range(0, BLOCK_BYTES));
      7:       return SIZE_W'(BLOCK_BYTES * $urandom_range(1, NUM_CLASSES));
      8:       return SIZE_W'(MAX_POOL_BYTES);
      9:       return SIZE_W'($urandom_range(MAX_POOL_BYTES + 1, 4095));
      default: return SIZE_W'($urandom_range(0, MAX_POOL_BYTES));
    endcase
  endfunction

  task automatic run_phase(input int count, input int idle, input int stall, input bit squeeze);
    int                r;
    int                pick;
    logic              c;
    logic [SIZE_W-1:0] s;
    logic [ADDR_W-1:0] a;
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      if (squeeze && i == 40) hold_request = 1'b1;
      r = $urandom_range(0, 99);
      a = ADDR_W'($urandom);
      if (r >= 60 && r < 88 && live_objs.size() != 0) begin
        pick = $urandom_range(0, live_objs.size() - 1);
        c    = CMD_FREE;
        s    = live_objs[pick].size;
        a    = live_objs[pick].addr;
        live_objs.delete(pick);
      end else if (r >= 88 && r < 96) begin
        // Stray free of an arbitrary block, sometimes with an oversized length.
        c = CMD_FREE;
        s = r[0] ? pick_size() : SIZE_W'($urandom);
      end else if (r >= 96) begin
        c = CMD_ALLOC;
        s = SIZE_W'($urandom);
      end else begin
        c = CMD_ALLOC;
        s = pick_size();
      end
      issue(c, s, a);
    end
    settle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Fresh chunk, the smallest and largest size classes at their edges, and oversized requests.
    issue(CMD_ALLOC, 12'd0, 12'h000);
    issue(CMD_ALLOC, 12'd1, 12'hFFF);
    issue(CMD_ALLOC, 12'd8, 12'h000);
    issue(CMD_ALLOC, 12'd9, 12'h000);
    issue(CMD_ALLOC, 12'd128, 12'h000);
    issue(CMD_ALLOC, 12'd127, 12'h000);
    issue(CMD_ALLOC, 12'd129, 12'h000);
    issue(CMD_ALLOC, 12'hFFF, 12'hFFF);
    issue(CMD_FREE, 12'hFFF, 12'hFFF);
    // Frees followed by pops, in last-in first-out order.
    issue(CMD_FREE, 12'd0, 12'h000);
    issue(CMD_FREE, 12'd8, 12'h002);
    issue(CMD_ALLOC, 12'd5, 12'h000);
    issue(CMD_ALLOC, 12'd0, 12'h000);
    issue(CMD_ALLOC, 12'd8, 12'h000);
    issue(CMD_FREE, 12'd128, 12'hFFF);
    issue(CMD_FREE, 12'd121, 12'hAAA);
    issue(CMD_ALLOC, 12'd128, 12'h000);
    issue(CMD_ALLOC, 12'd128, 12'h000);
    issue(CMD_ALLOC, 12'd128, 12'h555);
    issue(CMD_FREE, 12'd16, 12'h555);
    issue(CMD_ALLOC, 12'd16, 12'h000);
    issue(CMD_FREE, 12'd64, 12'h800);
    settle();

    run_phase(PHASE_ITEMS, 0, 0, 1'b1);
    run_phase(PHASE_ITEMS, 78, 0, 1'b0);
    run_phase(PHASE_ITEMS, 0, 78, 1'b0);
    run_phase(PHASE_ITEMS, 16, 16, 1'b0);

    repeat (10) @(posedge clk);
    if (fail_count == 0 && owed == 0) begin
      $display("PASS size_class_block_allocator");
    end else begin
      $display("FAIL size_class_block_allocator");
    end
    $finish;
  end

endmodule
